// ----- src/ply_pkg.sv -----
package ply_pkg;

  localparam int LetterW = 5;
  localparam int Side    = 5;
  localparam int RowW    = 3;
  localparam int WideW   = 50;
  localparam int NarrowW = 25;
  localparam int CfgIdxW = 2;

  localparam logic [LetterW-1:0] CODE_I = 5'd8;
  localparam logic [LetterW-1:0] CODE_J = 5'd9;
  localparam logic [LetterW-1:0] CODE_Q = 5'd16;
  localparam logic [LetterW-1:0] CODE_X = 5'd23;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECRYPT_MODE = 2'd0,
    CFG_ROWS_UPPER   = 2'd1,
    CFG_ROWS_MIDDLE  = 2'd2,
    CFG_ROW_BOTTOM   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               final_letter;
  } in_t;

  typedef struct packed {
    logic [LetterW-1:0] first_out;
    logic [LetterW-1:0] second_out;
    logic               odd_length;
    logic               end_of_message;
  } out_t;

  function automatic logic [LetterW-1:0] filler_for(input logic [LetterW-1:0] code);
    return (code == CODE_X) ? CODE_Q : CODE_X;
  endfunction

  function automatic logic [RowW-1:0] step_fwd(input logic [RowW-1:0] v);
    return (v == RowW'(Side - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [RowW-1:0] step_back(input logic [RowW-1:0] v);
    return (v == '0) ? RowW'(Side - 1) : v - 1'b1;
  endfunction

endpackage

// ----- src/playfair_digraph_cipher_top.sv -----
// channel | ports                            | beat
// input   | in_valid, in_stall, in_data      | one letter plus final flag
// output  | out_valid, out_stall, out_data   | one substituted digraph
// config  | cfg_we, cfg_index, cfg_wdata     | one register write
//
// one letter accepted per cycle while in_stall is low
// the pair register and then the result register hold each digraph; they form the two stages
// a doubled final letter in encrypt mode gives two beats and holds the result register until
// the second beat is taken, so a pair waiting behind it stalls the input until then
// synchronous active-low reset clears the held letter, the stage valids and the config registers
// out_stall reaches in_stall combinationally through the two stage enables
module playfair_digraph_cipher_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ply_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ply_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [ply_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ply_pkg::WideW-1:0]    cfg_wdata
);
  import ply_pkg::*;

  // configuration
  logic                 decrypt_r;
  logic [WideW-1:0]     sq_upper_r;
  logic [WideW-1:0]     sq_middle_r;
  logic [NarrowW-1:0]   sq_bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r   <= 1'b0;
      sq_upper_r  <= '0;
      sq_middle_r <= '0;
      sq_bottom_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DECRYPT_MODE: decrypt_r   <= cfg_wdata[0];
        CFG_ROWS_UPPER:   sq_upper_r  <= cfg_wdata;
        CFG_ROWS_MIDDLE:  sq_middle_r <= cfg_wdata;
        CFG_ROW_BOTTOM:   sq_bottom_r <= cfg_wdata[NarrowW-1:0];
        default: ;
      endcase
    end
  end

  logic [2*WideW+NarrowW-1:0] sq_flat;
  logic [LetterW-1:0]         sq [Side][Side];

  assign sq_flat = {sq_bottom_r, sq_middle_r, sq_upper_r};

  always_comb begin
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        sq[r][c] = sq_flat[(r*Side + c)*LetterW +: LetterW];
      end
    end
  end

  // handshake control
  logic in_acc, out_acc;
  logic p_valid_r, out_valid_r, rep_r;
  logic p_free, out_free, out_ld;

  assign out_acc  = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || (out_acc && !rep_r);
  assign out_ld   = p_valid_r && out_free;
  assign p_free   = !p_valid_r || out_ld;
  assign in_stall = !p_free;
  assign in_acc   = in_valid && !in_stall;

  // pairing of letters
  logic                held_valid_r, held_valid_nxt;
  logic [LetterW-1:0]  held_letter_r, held_letter_nxt;
  logic [LetterW-1:0]  ch;
  logic                emit;
  logic [LetterW-1:0]  pa_nxt, pb_nxt;
  logic                podd_nxt, pend_nxt, pdbl_nxt;

  logic [LetterW-1:0]  pa_r, pb_r;
  logic                podd_r, pend_r, pdbl_r;

  always_comb begin
    ch              = (in_data.letter == CODE_J) ? CODE_I : in_data.letter;
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    emit            = 1'b0;
    pa_nxt          = held_letter_r;
    pb_nxt          = ch;
    podd_nxt        = 1'b0;
    pend_nxt        = in_data.final_letter;
    pdbl_nxt        = 1'b0;
    if (!held_valid_r) begin
      if (in_data.final_letter) begin
        emit     = 1'b1;
        pa_nxt   = ch;
        pb_nxt   = filler_for(ch);
        podd_nxt = decrypt_r;
      end else begin
        held_valid_nxt  = 1'b1;
        held_letter_nxt = ch;
      end
    end else if (!decrypt_r && ch == held_letter_r) begin
      // doubled letter: pad the held one, the new one stays held unless it is the final letter
      emit     = 1'b1;
      pb_nxt   = filler_for(held_letter_r);
      pdbl_nxt = in_data.final_letter;
      if (in_data.final_letter) begin
        held_valid_nxt = 1'b0;
      end
    end else begin
      emit           = 1'b1;
      held_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
      p_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        held_valid_r  <= held_valid_nxt;
        held_letter_r <= held_letter_nxt;
      end
      if (p_free) begin
        p_valid_r <= in_acc && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && p_free) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      podd_r <= podd_nxt;
      pend_r <= pend_nxt;
      pdbl_r <= pdbl_nxt;
    end
  end

  // square lookup and substitution
  logic [RowW-1:0]    r1, c1, r2, c2;
  logic [RowW-1:0]    or1, oc1, or2, oc2;
  logic [LetterW-1:0] o1, o2;

  always_comb begin
    r1 = '0;
    c1 = '0;
    r2 = '0;
    c2 = '0;
    // last match in row-major order wins, no match sits at row 0 column 0
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (sq[r][c] == pa_r) begin
          r1 = RowW'(r);
          c1 = RowW'(c);
        end
        if (sq[r][c] == pb_r) begin
          r2 = RowW'(r);
          c2 = RowW'(c);
        end
      end
    end
  end

  always_comb begin
    if (r1 == r2) begin
      or1 = r1;
      or2 = r2;
      oc1 = decrypt_r ? step_back(c1) : step_fwd(c1);
      oc2 = decrypt_r ? step_back(c2) : step_fwd(c2);
    end else if (c1 == c2) begin
      or1 = decrypt_r ? step_back(r1) : step_fwd(r1);
      or2 = decrypt_r ? step_back(r2) : step_fwd(r2);
      oc1 = c1;
      oc2 = c2;
    end else begin
      or1 = r1;
      or2 = r2;
      oc1 = c2;
      oc2 = c1;
    end
    o1 = sq[or1][oc1];
    o2 = sq[or2][oc2];
  end

  // result register
  logic [LetterW-1:0] out_first_r, out_second_r;
  logic               out_odd_r, out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rep_r       <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
      rep_r       <= pdbl_r;
    end else if (out_acc) begin
      // after the first beat of a doubled final letter the result stays valid for the second beat
      out_valid_r <= rep_r;
      rep_r       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_first_r  <= o1;
      out_second_r <= o2;
      out_odd_r    <= podd_r;
      out_end_r    <= pend_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_data.first_out      = out_first_r;
  assign out_data.second_out     = out_second_r;
  assign out_data.odd_length     = out_odd_r;
  assign out_data.end_of_message = out_end_r && !rep_r;

  // checks
  a_rep_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> out_valid_r)
    else $error("repeat beat pending without a valid result");

  a_rep_then_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && rep_r) |=> (out_valid_r && !rep_r && out_data.end_of_message))
    else $error("second beat of a doubled final letter missing");

  a_final_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.final_letter) |=> !held_valid_r)
    else $error("letter still held after a final letter");

  a_odd_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.odd_length) |-> out_data.end_of_message)
    else $error("odd length flagged on a beat that does not end the message");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (p_valid_r && out_valid_r))
    else $error("input stalled while a stage is free");

endmodule

// ----- tb/playfair_digraph_cipher_top_tb.sv -----
`timescale 1ns / 100ps

module playfair_digraph_cipher_top_tb;
  import ply_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int PhaseCount = 12;
  localparam int PhaseLetters = 50;

  typedef enum int {
    SQ_ALPHABET,
    SQ_ZERO,
    SQ_ONES,
    SQ_SHUFFLED,
    SQ_SPOILED,
    SQ_RANDOM
  } sq_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_DECRYPT_MODE;
  logic [WideW-1:0] cfg_wdata = '0;

  // cipher state as the block should hold it
  logic [LetterW-1:0] key_square [25];
  logic dec_mode = 1'b0;
  logic [LetterW-1:0] held_code = '0;
  logic held_ok = 1'b0;

  out_t digraph_q [$];
  in_t letter_q [$];
  logic [LetterW-1:0] gen_sq [25];

  logic in_taken = 1'b0;
  logic in_busy = 1'b0;
  logic no_gaps = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int letters_in = 0;
  int beats_checked = 0;
  int odd_seen = 0;
  int ends_seen = 0;
  int settings_used = 0;

  playfair_digraph_cipher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < 25; k++) begin
      key_square[k] = '0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LetterW-1:0] pad_letter(input logic [LetterW-1:0] code);
    return (code == CODE_X) ? CODE_Q : CODE_X;
  endfunction

  function automatic int find_cell(input logic [LetterW-1:0] code);
    int pos;
    pos = 0;
    for (int k = 0; k < 25; k++) begin
      if (key_square[k] == code) begin
        pos = k;
      end
    end
    return pos;
  endfunction

  function automatic out_t cipher_pair(input logic [LetterW-1:0] a, input logic [LetterW-1:0] b,
                                       input logic dec, input logic odd, input logic fin);
    int pa, pb, sh;
    out_t o;
    pa = find_cell(a);
    pb = find_cell(b);
    sh = dec ? Side - 1 : 1;
    if (pa / Side == pb / Side) begin
      o.first_out  = key_square[pa / Side * Side + (pa % Side + sh) % Side];
      o.second_out = key_square[pb / Side * Side + (pb % Side + sh) % Side];
    end else if (pa % Side == pb % Side) begin
      o.first_out  = key_square[((pa / Side + sh) % Side) * Side + pa % Side];
      o.second_out = key_square[((pb / Side + sh) % Side) * Side + pb % Side];
    end else begin
      o.first_out  = key_square[pa / Side * Side + pb % Side];
      o.second_out = key_square[pb / Side * Side + pa % Side];
    end
    o.odd_length = odd;
    o.end_of_message = fin;
    return o;
  endfunction

  function automatic void take_letter(input in_t item);
    logic [LetterW-1:0] ch;
    ch = (item.letter == CODE_J) ? CODE_I : item.letter;
    if (!held_ok) begin
      if (item.final_letter) begin
        digraph_q.push_back(cipher_pair(ch, pad_letter(ch), dec_mode, dec_mode, 1'b1));
      end else begin
        held_code = ch;
        held_ok = 1'b1;
      end
    end else if (!dec_mode && ch == held_code) begin
      digraph_q.push_back(cipher_pair(held_code, pad_letter(held_code), 1'b0, 1'b0, 1'b0));
      if (item.final_letter) begin
        digraph_q.push_back(cipher_pair(ch, pad_letter(ch), 1'b0, 1'b0, 1'b1));
        held_ok = 1'b0;
        held_code = '0;
      end
    end else begin
      digraph_q.push_back(cipher_pair(held_code, ch, dec_mode, 1'b0, item.final_letter));
      held_ok = 1'b0;
      held_code = '0;
    end
  endfunction

  task automatic note_fault(input string what, input out_t want, input out_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected %0d/%0d odd=%0b end=%0b, got %0d/%0d odd=%0b end=%0b",
               $realtime, what, want.first_out, want.second_out, want.odd_length,
               want.end_of_message, got.first_out, got.second_out, got.odd_length,
               got.end_of_message);
    end
  endtask

  // letter driver
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy = 1'b0;
    end
    if (!in_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (letter_q.size() > 0) begin
        in_busy = 1'b1;
        in_data <= letter_q.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    out_t want;
    logic busy;
    if (rst_n) begin
      busy = cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECRYPT_MODE: dec_mode = cfg_wdata[0];
          CFG_ROWS_UPPER: begin
            for (int k = 0; k < 10; k++) key_square[k] = cfg_wdata[5*k +: 5];
          end
          CFG_ROWS_MIDDLE: begin
            for (int k = 0; k < 10; k++) key_square[10 + k] = cfg_wdata[5*k +: 5];
          end
          CFG_ROW_BOTTOM: begin
            for (int k = 0; k < 5; k++) key_square[20 + k] = cfg_wdata[5*k +: 5];
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_letter(in_data);
        in_taken = 1'b1;
        letters_in++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (digraph_q.size() == 0) begin
          note_fault("unexpected digraph", '0, out_data);
        end else begin
          want = digraph_q.pop_front();
          beats_checked++;
          if (want.odd_length) odd_seen++;
          if (want.end_of_message) ends_seen++;
          if (out_data.first_out !== want.first_out ||
              out_data.second_out !== want.second_out ||
              out_data.odd_length !== want.odd_length ||
              out_data.end_of_message !== want.end_of_message) begin
            note_fault("digraph mismatch", want, out_data);
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout with %0d digraphs outstanding", digraph_q.size());
        $display("playfair_digraph_cipher_top test failed");
        $finish;
      end
    end
  end

  function automatic void send_letter(input logic [LetterW-1:0] code, input logic fin);
    in_t item;
    item.letter = code;
    item.final_letter = fin;
    letter_q.push_back(item);
  endfunction

  function automatic void build_square(input sq_kind_t kind);
    int n, m;
    logic [LetterW-1:0] tmp;
    n = 0;
    for (int k = 0; k < 26; k++) begin
      if (k != int'(CODE_J)) begin
        gen_sq[n] = LetterW'(k);
        n++;
      end
    end
    if (kind != SQ_ALPHABET) begin
      for (int k = 24; k > 0; k--) begin
        m = $urandom_range(0, k);
        tmp = gen_sq[k];
        gen_sq[k] = gen_sq[m];
        gen_sq[m] = tmp;
      end
    end
    for (int k = 0; k < 25; k++) begin
      case (kind)
        SQ_ZERO: gen_sq[k] = '0;
        SQ_ONES: gen_sq[k] = '1;
        SQ_SPOILED: if ($urandom_range(0, 4) == 0) gen_sq[k] = LetterW'($urandom_range(0, 31));
        SQ_RANDOM: gen_sq[k] = LetterW'($urandom_range(0, 31));
        default: ;
      endcase
    end
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [WideW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic load_setting(input logic mode);
    logic [WideW-1:0] w;
    w = WideW'({$urandom, $urandom});
    w[0] = mode;
    write_reg(CFG_DECRYPT_MODE, w);
    for (int k = 0; k < 10; k++) w[5*k +: 5] = gen_sq[k];
    write_reg(CFG_ROWS_UPPER, w);
    for (int k = 0; k < 10; k++) w[5*k +: 5] = gen_sq[10 + k];
    write_reg(CFG_ROWS_MIDDLE, w);
    w = WideW'({$urandom, $urandom});
    for (int k = 0; k < 5; k++) w[5*k +: 5] = gen_sq[20 + k];
    write_reg(CFG_ROW_BOTTOM, w);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain_and_settle();
    do @(negedge clk);
    while (letter_q.size() != 0 || in_busy || digraph_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int sent, msg_len, r;
    logic [LetterW-1:0] prev_code, code;
    logic mode;
    sq_kind_t kind;
    prev_code = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    build_square(SQ_ALPHABET);
    load_setting(1'b0);
    send_letter(5'd0, 1'b0);  send_letter(5'd1, 1'b0);
    send_letter(5'd0, 1'b0);  send_letter(5'd5, 1'b0);
    send_letter(5'd0, 1'b0);  send_letter(5'd25, 1'b0);
    send_letter(CODE_J, 1'b0); send_letter(5'd10, 1'b0);
    send_letter(5'd4, 1'b0);  send_letter(5'd4, 1'b0);  send_letter(5'd7, 1'b0);
    send_letter(CODE_X, 1'b0); send_letter(CODE_X, 1'b0); send_letter(CODE_X, 1'b1);
    send_letter(CODE_Q, 1'b1);
    send_letter(CODE_X, 1'b1);
    send_letter(5'd31, 1'b0); send_letter(5'd26, 1'b1);
    send_letter(5'd11, 1'b0);
    drain_and_settle();
    load_setting(1'b1);
    send_letter(5'd12, 1'b0);
    send_letter(5'd0, 1'b0);  send_letter(5'd21, 1'b0);
    send_letter(5'd6, 1'b0);  send_letter(5'd6, 1'b0);
    send_letter(5'd2, 1'b0);  send_letter(5'd19, 1'b0);
    send_letter(5'd3, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_and_settle();
      if (p == 0) begin
        kind = SQ_ZERO;
        mode = 1'b0;
      end else if (p == 1) begin
        kind = SQ_ONES;
        mode = 1'b1;
      end else begin
        r = $urandom_range(0, 9);
        kind = (r < 6) ? SQ_SHUFFLED : (r < 8) ? SQ_SPOILED : SQ_RANDOM;
        mode = ($urandom_range(0, 1) != 0);
      end
      build_square(kind);
      no_gaps = ($urandom_range(0, 3) == 0);
      load_setting(mode);
      sent = 0;
      while (sent < PhaseLetters) begin
        if ($urandom_range(0, 99) < 85) begin
          msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
          for (int i = 0; i < msg_len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) code = gen_sq[$urandom_range(0, 24)];
            else if (r < 82) code = prev_code;
            else if (r < 87) code = CODE_J;
            else code = LetterW'($urandom_range(0, 31));
            send_letter(code, i == msg_len - 1);
            prev_code = code;
            sent++;
          end
        end else begin
          code = LetterW'($urandom_range(0, 31));
          send_letter(code, $urandom_range(0, 3) == 0);
          prev_code = code;
          sent++;
        end
      end
    end

    no_gaps = 1'b0;
    drain_and_settle();
    $display("%0d letters over %0d key/mode settings, %0d digraphs checked",
             letters_in, settings_used, beats_checked);
    $display("%0d message ends seen, %0d of them padded odd-length decrypts", ends_seen, odd_seen);
    if (errors == 0) begin
      $display("playfair_digraph_cipher_top test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("playfair_digraph_cipher_top test failed");
    end
    $finish;
  end

endmodule
